// File: rtl/bus_region_address_decoder_macros.svh
// Assertion macros for the bus region address decoder.
// Used by the controller and the top level; no other dependencies.
`ifndef BUS_REGION_ADDRESS_DECODER_MACROS_SVH
`define BUS_REGION_ADDRESS_DECODER_MACROS_SVH
// check a property on every clock edge outside reset
`define BRAD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// check a property during and after reset
`define BRAD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

// File: rtl/brad_pkg.sv
// Shared types and codes for the bus region address decoder.
// No dependencies.
package brad_pkg;
    localparam logic [3:0] ST_HIT      = 4'd0;
    localparam logic [3:0] ST_NODEV    = 4'd1;
    localparam logic [3:0] ST_STRADDLE = 4'd2;
    localparam logic [3:0] ST_BADACC   = 4'd3;
    localparam logic [3:0] ST_ADDED    = 4'd4;
    localparam logic [3:0] ST_ZERO     = 4'd5;
    localparam logic [3:0] ST_WRAP     = 4'd6;
    localparam logic [3:0] ST_OVERLAP  = 4'd7;
    localparam logic [3:0] ST_FULL     = 4'd8;

    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_ACCESS = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;   // capture the command
        logic eval;   // compare and update the table
        logic show;   // drive the result
    } t_ctrl;
endpackage

// File: rtl/brad_ctrl.sv
// Controller state machine for the bus region address decoder.
// Depends on brad_pkg and the macros header.
`include "bus_region_address_decoder_macros.svh"
module brad_ctrl
    import brad_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    output logic   o_busy,
    output t_ctrl  o_ctrl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_start) n_state = S_EVAL;
            S_EVAL: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_busy      = 1'b0;
                o_ctrl.load = i_start;
            end
            S_EVAL: o_ctrl.eval = 1'b1;
            S_DONE: o_ctrl.show = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

    `BRAD_ASSERT(a_eval_follows_load, i_clk, i_rst_n, o_ctrl.load |=> o_ctrl.eval, "eval lost")
    `BRAD_ASSERT(a_show_follows_eval, i_clk, i_rst_n, o_ctrl.eval |=> o_ctrl.show, "show lost")
    `BRAD_ASSERT(a_one_cmd, i_clk, i_rst_n, $onehot0(o_ctrl), "commands overlap")
endmodule

// File: rtl/brad_dp.sv
// Datapath: region table, parallel comparators and result register.
// Depends on brad_pkg.
module brad_dp
    import brad_pkg::*;
#(
    parameter int MAX_REGIONS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctrl       i_ctrl,
    input  logic        i_cmd,
    input  logic [63:0] i_addr,
    input  logic [12:0] i_len,
    input  logic [63:0] i_region_size,
    output logic        o_valid,
    output logic [3:0]  o_status,
    output logic [2:0]  o_region,
    output logic [63:0] o_offset,
    output logic [63:0] o_bus_end
);
    localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);

    logic [63:0] r_base [MAX_REGIONS];
    logic [63:0] r_size [MAX_REGIONS];
    logic [MAX_REGIONS-1:0] r_vld;
    logic [CW-1:0] r_count;

    logic        r_cmd;
    logic [63:0] r_addr, r_size_in, r_last;
    logic [12:0] r_len;
    logic        r_wrap;

    logic [63:0] r_end;      // end of highest-based region
    logic [63:0] r_hibase;
    logic [3:0]  r_status;
    logic [2:0]  r_region;
    logic [63:0] r_offset;

    // capture; compute last byte and wrap once here
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd     <= i_cmd;
            r_addr    <= i_addr;
            r_len     <= i_len;
            r_size_in <= i_region_size;
            if (i_cmd == CMD_ADD) begin
                {r_wrap, r_last} <= {1'b0, i_addr} + {1'b0, i_region_size - 64'd1};
            end else begin
                {r_wrap, r_last} <= {1'b0, i_addr} + 65'(i_len - 13'd1);
            end
        end
    end

    logic [MAX_REGIONS-1:0] touch, contain;
    logic [63:0] rel [MAX_REGIONS];
    always_comb begin
        for (int i = 0; i < MAX_REGIONS; i++) begin
            rel[i]     = r_addr - r_base[i];
            touch[i]   = r_vld[i] && r_base[i] <= r_last
                         && (r_base[i] + (r_size[i] - 64'd1)) >= r_addr;
            contain[i] = r_vld[i] && r_addr >= r_base[i] && rel[i] < r_size[i]
                         && (rel[i] + 64'(r_len - 13'd1)) < r_size[i];
        end
    end

    logic [IW-1:0] hit_idx;
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < MAX_REGIONS; i++)
            if (contain[i]) hit_idx = IW'(i);
    end

    logic add_ok;
    assign add_ok = r_cmd == CMD_ADD && r_size_in != 64'd0 && !r_wrap && touch == '0
                    && r_count < CW'(MAX_REGIONS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_count <= '0;
            r_end   <= '0;
        end else if (i_ctrl.eval && add_ok) begin
            r_vld[r_count[IW-1:0]] <= 1'b1;
            r_count                <= r_count + CW'(1);
            if (r_vld == '0 || r_addr > r_hibase) r_end <= r_addr + r_size_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.eval && add_ok) begin
            r_base[r_count[IW-1:0]] <= r_addr;
            r_size[r_count[IW-1:0]] <= r_size_in;
            if (r_vld == '0 || r_addr > r_hibase) r_hibase <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.eval) begin
            r_region <= 3'd0;
            r_offset <= 64'd0;
            if (r_cmd == CMD_ADD) begin
                if (r_size_in == 64'd0)             r_status <= ST_ZERO;
                else if (r_wrap)                    r_status <= ST_WRAP;
                else if (touch != '0)               r_status <= ST_OVERLAP;
                else if (r_count >= CW'(MAX_REGIONS)) r_status <= ST_FULL;
                else begin
                    r_status <= ST_ADDED;
                    r_region <= 3'(r_count);
                end
            end else if (r_len == 13'd0 || r_wrap) begin
                r_status <= ST_BADACC;
            end else if (contain != '0) begin
                r_status <= ST_HIT;
                r_region <= 3'(hit_idx);
                r_offset <= rel[hit_idx];
            end else if (touch != '0) begin
                r_status <= ST_STRADDLE;
            end else begin
                r_status <= ST_NODEV;
            end
        end
    end

    assign o_valid   = i_ctrl.show;
    assign o_status  = r_status;
    assign o_region  = r_region;
    assign o_offset  = r_offset;
    assign o_bus_end = r_end;
endmodule

// File: rtl/bus_region_address_decoder.sv
// A command taken while idle is loaded, then evaluated, and its result strobe comes in the report state.
// A new command is taken only when the controller is idle, after its load/evaluate/report
// sequence ends; the region comparators are combinational and work in parallel.
// Reset (synchronous, active low) empties the table and idles the controller.
// The receiver cannot stall: o_valid lasts exactly one cycle.
// Depends on brad_pkg, brad_ctrl, brad_dp and the macros header.
`include "bus_region_address_decoder_macros.svh"
module bus_region_address_decoder
    import brad_pkg::*;
#(
    parameter int MAX_REGIONS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic [63:0] i_addr,
    input  logic [12:0] i_len,
    input  logic [63:0] i_region_size,
    output logic        o_valid,
    output logic [3:0]  o_status,
    output logic [2:0]  o_region,
    output logic [63:0] o_offset,
    output logic [63:0] o_bus_end
);
    t_ctrl ctrl;

    // sequence each transfer: load, evaluate, report
    brad_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_ctrl  (ctrl)
    );

    // hold the region table and decode
    brad_dp #(.MAX_REGIONS(MAX_REGIONS)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_cmd         (i_cmd),
        .i_addr        (i_addr),
        .i_len         (i_len),
        .i_region_size (i_region_size),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_region      (o_region),
        .o_offset      (o_offset),
        .o_bus_end     (o_bus_end)
    );

    `BRAD_ASSERT(a_result_two_after, i_clk, i_rst_n, (start && !busy) |=> ##1 o_valid, "no result")
    `BRAD_ASSERT(a_busy_on_result, i_clk, i_rst_n, o_valid |-> busy, "result while idle")
    `BRAD_ASSERT(a_status_range, i_clk, i_rst_n, o_valid |-> o_status <= ST_FULL, "bad status")
endmodule
